>>> hdl/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;

    localparam int ADDR_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int Q_DEPTH  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [6:0] RST_ROWS    = 7'd25;

    localparam logic [7:0]  CH_BS        = 8'h08;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_LF        = 8'h0A;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_PRINT_MAX = 8'h7F;
    localparam logic [15:0] BLANK_CELL   = 16'h0F20;
    localparam int          TAB_STEP     = 8;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        KIND_READ  = 3'd0,
        KIND_BS    = 3'd1,
        KIND_TAB   = 3'd2,
        KIND_CR    = 3'd3,
        KIND_LF    = 3'd4,
        KIND_PRINT = 3'd5,
        KIND_NOP   = 3'd6
    } t_kind;

    typedef struct packed {
        logic              action;
        logic [7:0]        char_code;
        logic [3:0]        fore_colour;
        logic [3:0]        back_colour;
        logic [ADDR_W-1:0] cell_address;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col;
        logic [5:0]  cursor_row;
        logic        scrolled;
    } t_out;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        char_code;
        logic [7:0]        attr;
        logic [ADDR_W-1:0] cell_address;
    } t_cmd;

endpackage

>>> hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tcw_front.sv
// Front end: configuration registers, screen geometry and command classification.
module tcw_front import tcw_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    localparam int CELLS = MAX_COLUMNS * MAX_ROWS,
    localparam int CW    = $clog2(CELLS + 1),
    localparam int CCW   = $clog2(MAX_COLUMNS + 1),
    localparam int RCW   = $clog2(MAX_ROWS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_q_full,
    input  logic                  i_clearing,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    output logic [CCW-1:0]        o_cols,
    output logic [RCW-1:0]        o_rows,
    output logic [CW-1:0]         o_area
);

    logic [7:0]     r_columns;
    logic [6:0]     r_rows;
    logic [CCW-1:0] r_cols_eff;
    logic [RCW-1:0] r_rows_eff;
    logic [CW-1:0]  r_area;
    logic [CCW-1:0] n_cols_eff;
    logic [RCW-1:0] n_rows_eff;
    t_kind          w_kind;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= RST_COLUMNS;
            r_rows    <= RST_ROWS;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_COLUMNS) begin
                r_columns <= i_cfg_data;
            end else if (i_cfg_index == CFG_ROWS) begin
                r_rows <= i_cfg_data[6:0];
            end
        end
    end

    // clamp to 1..max
    always_comb begin
        if (r_columns == '0) begin
            n_cols_eff = CCW'(1);
        end else if (int'(r_columns) > MAX_COLUMNS) begin
            n_cols_eff = CCW'(MAX_COLUMNS);
        end else begin
            n_cols_eff = CCW'(r_columns);
        end
        if (r_rows == '0) begin
            n_rows_eff = RCW'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            n_rows_eff = RCW'(MAX_ROWS);
        end else begin
            n_rows_eff = RCW'(r_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cols_eff <= n_cols_eff;
        r_rows_eff <= n_rows_eff;
        r_area     <= CW'((CCW + RCW)'(n_cols_eff) * (CCW + RCW)'(n_rows_eff));
    end

    assign o_cols = r_cols_eff;
    assign o_rows = r_rows_eff;
    assign o_area = r_area;

    always_comb begin
        if (i_in_data.action == ACT_READ) begin
            w_kind = KIND_READ;
        end else begin
            unique case (i_in_data.char_code)
                CH_BS:   w_kind = KIND_BS;
                CH_TAB:  w_kind = KIND_TAB;
                CH_CR:   w_kind = KIND_CR;
                CH_LF:   w_kind = KIND_LF;
                default: begin
                    if (i_in_data.char_code >= CH_SPACE &&
                        i_in_data.char_code <= CH_PRINT_MAX) begin
                        w_kind = KIND_PRINT;
                    end else begin
                        w_kind = KIND_NOP;
                    end
                end
            endcase
        end
    end

    assign o_in_ready         = !i_q_full && !i_clearing;
    assign o_push             = i_in_valid && o_in_ready;
    assign o_cmd.kind         = w_kind;
    assign o_cmd.char_code    = i_in_data.char_code;
    assign o_cmd.attr         = {i_in_data.back_colour, i_in_data.fore_colour};
    assign o_cmd.cell_address = i_in_data.cell_address;

endmodule

>>> hdl/tcw_queue.sv
// Short command queue between the front end and the back end.
module tcw_queue import tcw_pkg::*; #(
    parameter int DEPTH = Q_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [NW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;

    always_comb begin
        n_wptr = (int'(r_wptr) == DEPTH - 1) ? '0 : r_wptr + PW'(1);
        n_rptr = (int'(r_rptr) == DEPTH - 1) ? '0 : r_rptr + PW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_full  = (int'(r_count) == DEPTH);
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rptr];

endmodule

>>> hdl/tcw_back.sv
// Back end: cursor, screen memory sequencing, scroll and clear passes, result register.
module tcw_back import tcw_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    localparam int CELLS = MAX_COLUMNS * MAX_ROWS,
    localparam int CW    = $clog2(CELLS + 1),
    localparam int CCW   = $clog2(MAX_COLUMNS + 1),
    localparam int RCW   = $clog2(MAX_ROWS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  t_cmd           i_cmd,
    output logic           o_pop,
    input  logic [CCW-1:0] i_cols,
    input  logic [RCW-1:0] i_rows,
    input  logic [CW-1:0]  i_area,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output t_out           o_out_data
);

    localparam int AW   = $clog2(CELLS);
    localparam int COLW = $clog2(MAX_COLUMNS);
    localparam int ROWW = $clog2(MAX_ROWS);
    localparam int XW   = CCW + 1;
    localparam int YW   = RCW + 1;
    localparam int LW   = XW + YW;
    localparam int MW   = (CW > ADDR_W) ? CW : ADDR_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_COPY  = 5'b01000,
        S_FILL  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [COLW-1:0] r_col, n_col;
    logic [ROWW-1:0] r_row, n_row;
    logic [CW-1:0]   r_sidx, n_sidx;
    logic [CW-1:0]   r_widx, n_widx;
    logic            r_pend, n_pend;
    logic            r_rd_zero, n_rd_zero;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    // put datapath
    logic [XW-1:0]   p_x, p_px, p_stop;
    logic [YW-1:0]   p_y, p_py;
    logic [LW-1:0]   p_lin;
    logic            p_wr;
    logic [7:0]      p_char;
    logic            p_scroll;
    logic            w_in_rng;
    logic            w_out_free;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        p_x = (XW'(r_col) >= XW'(i_cols)) ? XW'(i_cols) - XW'(1) : XW'(r_col);
        p_y = (YW'(r_row) >= YW'(i_rows)) ? YW'(i_rows) - YW'(1) : YW'(r_row);
        p_stop = (p_x + XW'(TAB_STEP)) & ~XW'(TAB_STEP - 1);
        p_wr   = 1'b0;
        p_char = i_cmd.char_code;
        unique case (i_cmd.kind)
            KIND_BS: begin
                if (p_x != '0) begin
                    p_x = p_x - XW'(1);
                end else begin
                    p_x = XW'(i_cols) - XW'(1);
                    if (p_y != '0) begin
                        p_y = p_y - YW'(1);
                    end
                end
                p_wr   = 1'b1;
                p_char = CH_SPACE;
            end
            KIND_TAB: begin
                if (p_stop < XW'(i_cols)) begin
                    p_x = p_stop;
                end
            end
            KIND_CR: begin
                p_x = '0;
            end
            KIND_LF: begin
                p_x = '0;
                p_y = p_y + YW'(1);
            end
            KIND_PRINT: begin
                p_wr = 1'b1;
            end
            default: begin
            end
        endcase
        // cell position is taken before a printable byte advances the cursor
        p_px  = p_x;
        p_py  = p_y;
        p_lin = LW'(p_py) * LW'(i_cols) + LW'(p_px);
        if (i_cmd.kind == KIND_PRINT) begin
            p_x = p_x + XW'(1);
        end
        if (p_x >= XW'(i_cols)) begin
            p_x = '0;
            p_y = p_y + YW'(1);
        end
        p_scroll = (p_y >= YW'(i_rows));
    end

    assign w_in_rng   = MW'(i_cmd.cell_address) < MW'(i_area);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_sidx      = r_sidx;
        n_widx      = r_widx;
        n_pend      = r_pend;
        n_rd_zero   = r_rd_zero;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        o_pop       = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_widx[AW-1:0];
                n_widx    = r_widx + CW'(1);
                if (r_widx == CW'(CELLS - 1)) begin
                    n_widx  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == KIND_READ) begin
                        ram_re    = w_in_rng;
                        ram_raddr = AW'(i_cmd.cell_address);
                        n_rd_zero = !w_in_rng;
                        n_state   = S_READ;
                    end else begin
                        ram_we    = p_wr;
                        ram_waddr = AW'(p_lin);
                        ram_wdata = {i_cmd.attr, p_char};
                        n_col     = COLW'(p_x);
                        n_row     = p_scroll ? ROWW'(i_rows - RCW'(1)) : ROWW'(p_y);
                        if (p_scroll) begin
                            n_sidx  = CW'(i_cols);
                            n_widx  = '0;
                            n_pend  = 1'b0;
                            n_state = S_COPY;
                        end else begin
                            n_out_valid      = 1'b1;
                            n_out.cell_value = '0;
                            n_out.cursor_col = 7'(COLW'(p_x));
                            n_out.cursor_row = 6'(ROWW'(p_y));
                            n_out.scrolled   = 1'b0;
                        end
                    end
                end
            end
            S_READ: begin
                n_out_valid      = 1'b1;
                n_out.cell_value = r_rd_zero ? '0 : ram_rdata;
                n_out.cursor_col = 7'(r_col);
                n_out.cursor_row = 6'(r_row);
                n_out.scrolled   = 1'b0;
                n_state          = S_IDLE;
            end
            S_COPY: begin
                // read one row ahead, write the cell one row up in the following cycle
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_widx[AW-1:0];
                    ram_wdata = ram_rdata;
                    n_widx    = r_widx + CW'(1);
                end
                if (r_sidx < i_area) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_sidx[AW-1:0];
                    n_sidx    = r_sidx + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_widx[AW-1:0];
                ram_wdata = BLANK_CELL;
                n_widx    = r_widx + CW'(1);
                if (r_widx == i_area - CW'(1)) begin
                    n_out_valid      = 1'b1;
                    n_out.cell_value = '0;
                    n_out.cursor_col = 7'(r_col);
                    n_out.cursor_row = 6'(r_row);
                    n_out.scrolled   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_widx      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_widx      <= n_widx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_sidx      <= n_sidx;
            r_rd_zero   <= n_rd_zero;
            r_out       <= n_out;
        end
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/text_console_writer_top.sv
// Top level of the text console writer: front end, command queue and back end.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction is a put of a
// character at the cursor or a read of one screen cell. Every transaction yields one
// result transaction on the output channel (o_out_valid / i_out_ready / o_out_data).
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets the
// column count, index 1 the row count; write them only while the block is idle.
// Path: a put without scroll passes the queue and then the result register; a read
// also passes the registered memory read and the S_READ state. A put that scrolls
// walks the screen through the separate read and write ports of the screen RAM: it
// copies every row up by one, then fills the last row with blank cells.
// Throughput: one put per cycle while nothing scrolls and i_out_ready stays high; a read
// holds the back-end sequencer in S_READ, so no new command is taken until it is through.
// Reset: the cursor goes to the origin and the screen RAM is cleared one cell per cycle
// over all MAX_COLUMNS*MAX_ROWS cells; o_in_ready stays low until that pass ends.
// Stall: the result register holds while i_out_ready is low; the two-entry queue keeps
// accepting until it fills, then o_in_ready drops.
module text_console_writer_top import tcw_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int CCW   = $clog2(MAX_COLUMNS + 1);
    localparam int RCW   = $clog2(MAX_ROWS + 1);

    logic           w_push;
    t_cmd           w_push_cmd;
    logic           w_q_full;
    logic           w_q_valid;
    t_cmd           w_q_cmd;
    logic           w_pop;
    logic           w_clearing;
    logic [CCW-1:0] w_cols;
    logic [RCW-1:0] w_rows;
    logic [CW-1:0]  w_area;

    tcw_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (w_q_full),
        .i_clearing  (w_clearing),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd),
        .o_cols      (w_cols),
        .o_rows      (w_rows),
        .o_area      (w_area)
    );

    tcw_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd),
        .i_pop   (w_pop)
    );

    tcw_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .i_cols      (w_cols),
        .i_rows      (w_rows),
        .i_area      (w_area),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.scrolled |->
            o_out_data.cursor_row == 6'(w_rows - RCW'(1)))
        else $error("scroll result not on the last row");

    a_scroll_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.scrolled |-> o_out_data.cell_value == '0)
        else $error("scroll result carries a cell value");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_out_valid && !w_pop)
        else $error("result or pop during clearing pass");

    a_pop_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking bench for the text console writer: directed script, then random traffic.
module testbench;
    import tcw_pkg::*;

    // Slowest legal run: a full-screen scroll on every item of the 128x64 phase, the smaller
    // phases likewise, the clearing pass after reset, and the longest stalls and gaps on
    // every item. RUN_LIMIT allows several times that.
    localparam int unsigned RUN_LIMIT   = 5_000_000;
    localparam int unsigned HOLD_AT     = 120;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned SCREEN_SIZE = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           data;
        t_in                  item;
        logic                 typed;
        t_out                 want;
    } t_step;

    typedef struct packed {
        logic [7:0]  cols;
        logic [7:0]  rows;
        logic [15:0] items;
        logic [7:0]  lf_pct;
    } t_phase;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the block: screen, cursor and size registers.
    logic [15:0] screen_model [SCREEN_SIZE];
    int unsigned cur_x;
    int unsigned cur_y;
    logic [7:0]  columns_reg;
    logic [6:0]  rows_reg;

    t_out        awaited_replies[$];
    t_step       script[$];
    t_phase      phases[$];
    int unsigned results_done;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    text_console_writer_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned active_cols();
        if (columns_reg == 0) return 1;
        if (columns_reg > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
        return 32'(columns_reg);
    endfunction

    function automatic int unsigned active_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return 32'(rows_reg);
    endfunction

    // Apply one transaction to the shadow screen and return the reply it must produce.
    function automatic t_out apply_console_op(t_in it);
        int unsigned cols;
        int unsigned nrows;
        int unsigned i;
        int unsigned next_stop;
        logic [15:0] attr;
        t_out        r;
        cols  = active_cols();
        nrows = active_rows();
        attr  = {it.back_colour, it.fore_colour, 8'h00};
        r     = '0;
        if (it.action == ACT_READ) begin
            if (it.cell_address < cols * nrows) r.cell_value = screen_model[it.cell_address];
        end else begin
            // pull the cursor back inside after a size change
            if (cur_x >= cols) cur_x = cols - 1;
            if (cur_y >= nrows) cur_y = nrows - 1;
            next_stop = ((cur_x / TAB_STEP) + 1) * TAB_STEP;
            if (it.char_code == CH_BS) begin
                if (cur_x != 0) begin
                    cur_x--;
                end else begin
                    cur_x = cols - 1;
                    if (cur_y > 0) cur_y--;
                end
                screen_model[cur_y * cols + cur_x] = attr | {8'h00, CH_SPACE};
            end else if (it.char_code == CH_TAB && next_stop < cols) begin
                cur_x = next_stop;
            end else if (it.char_code == CH_CR) begin
                cur_x = 0;
            end else if (it.char_code == CH_LF) begin
                cur_x = 0;
                cur_y++;
            end else if (it.char_code >= CH_SPACE && it.char_code <= CH_PRINT_MAX) begin
                screen_model[cur_y * cols + cur_x] = attr | {8'h00, it.char_code};
                cur_x++;
            end
            if (cur_x >= cols) begin
                cur_x = 0;
                cur_y++;
            end
            if (cur_y >= nrows) begin
                for (i = 0; i < (nrows - 1) * cols; i++) screen_model[i] = screen_model[i + cols];
                for (i = (nrows - 1) * cols; i < nrows * cols; i++) screen_model[i] = BLANK_CELL;
                cur_y = nrows - 1;
                r.scrolled = 1'b1;
            end
        end
        r.cursor_col = cur_x[6:0];
        r.cursor_row = cur_y[5:0];
        return r;
    endfunction

    function automatic t_step put_step(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
        t_step s;
        s = '0;
        s.item.action      = ACT_PUT;
        s.item.char_code   = ch;
        s.item.fore_colour = fg;
        s.item.back_colour = bg;
        return s;
    endfunction

    function automatic t_step read_step(logic [ADDR_W-1:0] addr);
        t_step s;
        s = '0;
        s.item.action       = ACT_READ;
        s.item.cell_address = addr;
        return s;
    endfunction

    function automatic t_step cfg_step(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        t_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic t_step with_reply(t_step s, logic [15:0] v, logic [6:0] col,
                                         logic [5:0] row, logic scr);
        t_step t;
        t = s;
        t.typed           = 1'b1;
        t.want.cell_value = v;
        t.want.cursor_col = col;
        t.want.cursor_row = row;
        t.want.scrolled   = scr;
        return t;
    endfunction

    function automatic t_in random_op(int unsigned lf_pct);
        t_in         it;
        int unsigned pick;
        int unsigned span;
        it.fore_colour  = 4'($urandom_range(0, 15));
        it.back_colour  = 4'($urandom_range(0, 15));
        it.cell_address = ADDR_W'($urandom_range(0, SCREEN_SIZE - 1));
        it.char_code    = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 20) begin
            it.action = ACT_READ;
            // mostly inside the active area, just past its end now and then
            if ($urandom_range(0, 9) < 7) begin
                span = active_cols() * active_rows();
                it.cell_address = ADDR_W'($urandom_range(0, span + 1));
            end
        end else begin
            it.action = ACT_PUT;
            pick = $urandom_range(0, 99);
            if (pick < lf_pct) it.char_code = CH_LF;
            else if (pick < lf_pct + 6) it.char_code = CH_CR;
            else if (pick < lf_pct + 14) it.char_code = CH_BS;
            else if (pick < lf_pct + 22) it.char_code = CH_TAB;
            else if (pick < lf_pct + 32) it.char_code = 8'($urandom_range(8'h80, 8'hFF));
            else if (pick < lf_pct + 38) it.char_code = 8'($urandom_range(0, CH_SPACE - 1));
            else it.char_code = 8'($urandom_range(CH_SPACE, CH_PRINT_MAX));
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance, valid still high.
    task automatic offer(t_in it, logic typed, t_out want);
        t_out predicted;
        in_valid = 1'b1;
        in_data  = it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = apply_console_op(it);
        awaited_replies.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (awaited_replies.size() != 0) @(negedge clk);
        // let the back end finish its last cycles
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_COLUMNS) columns_reg = data;
        else if (idx == CFG_ROWS) rows_reg = data[6:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_phase(int unsigned count, int unsigned lf_pct);
        int unsigned left;
        int unsigned burst;
        int unsigned gap;
        int unsigned k;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && left > 0; k++) begin
                offer(random_op(lf_pct), 1'b0, '0);
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Receiver: segments of different ready patterns, plus one long hold-off.
    initial begin
        int unsigned seg;
        int unsigned mode;
        bit          held;
        held      = 1'b0;
        out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(4, 60);
            repeat (seg) begin
                @(negedge clk);
                if (!held && results_done >= HOLD_AT) begin
                    held      = 1'b1;
                    out_ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    2: out_ready = ($urandom_range(0, 3) == 0);
                    default: out_ready = ~out_ready;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_replies.size() == 0) begin
                $error("reply transaction with nothing outstanding: %h", out_data);
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (out_data.cell_value !== want.cell_value) begin
                    $error("cell_value: expected %h, got %h", want.cell_value, out_data.cell_value);
                    mismatch_count++;
                end
                if (out_data.cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d", want.cursor_col,
                           out_data.cursor_col);
                    mismatch_count++;
                end
                if (out_data.cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row,
                           out_data.cursor_row);
                    mismatch_count++;
                end
                if (out_data.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, out_data.scrolled);
                    mismatch_count++;
                end
            end
            results_done++;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned i;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_COLUMNS;
        cfg_data       = '0;
        results_done   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        cur_x          = 0;
        cur_y          = 0;
        columns_reg    = RST_COLUMNS;
        rows_reg       = RST_ROWS;
        for (i = 0; i < SCREEN_SIZE; i++) screen_model[i] = '0;

        // Default 80x25 screen after reset.
        script.push_back(with_reply(read_step(13'd0), 16'h0000, 7'd0, 6'd0, 1'b0));
        script.push_back(with_reply(read_step(13'd8191), 16'h0000, 7'd0, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(8'h41, 4'hF, 4'hF), 16'h0000, 7'd1, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(CH_SPACE, 4'h0, 4'h0), 16'h0000, 7'd2, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(CH_PRINT_MAX, 4'h5, 4'hA), 16'h0000, 7'd3, 6'd0,
                                    1'b0));
        script.push_back(with_reply(read_step(13'd0), 16'hFF41, 7'd3, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(8'h80, 4'h1, 4'h2), 16'h0000, 7'd3, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(8'h1F, 4'h1, 4'h2), 16'h0000, 7'd3, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(CH_TAB, 4'h0, 4'h0), 16'h0000, 7'd8, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(CH_BS, 4'h2, 4'h1), 16'h0000, 7'd7, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(CH_CR, 4'h0, 4'h0), 16'h0000, 7'd0, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(CH_BS, 4'h3, 4'h4), 16'h0000, 7'd79, 6'd0, 1'b0));
        script.push_back(with_reply(read_step(13'd79), 16'h4320, 7'd79, 6'd0, 1'b0));
        script.push_back(with_reply(put_step(8'h78, 4'h7, 4'h0), 16'h0000, 7'd0, 6'd1, 1'b0));
        script.push_back(with_reply(put_step(CH_LF, 4'h0, 4'h0), 16'h0000, 7'd0, 6'd2, 1'b0));
        script.push_back(with_reply(read_step(13'd2000), 16'h0000, 7'd0, 6'd2, 1'b0));
        // Shrink to 10x2 with the cursor left below the last row.
        script.push_back(cfg_step(CFG_COLUMNS, 8'd10));
        script.push_back(cfg_step(CFG_ROWS, 8'd2));
        script.push_back(put_step(8'h79, 4'h1, 4'h0));
        script.push_back(put_step(CH_TAB, 4'h0, 4'h0));
        script.push_back(put_step(CH_TAB, 4'h0, 4'h0));
        script.push_back(put_step(8'h61, 4'h6, 4'h9));
        script.push_back(with_reply(put_step(8'h62, 4'h6, 4'h9), 16'h0000, 7'd0, 6'd1, 1'b1));
        script.push_back(with_reply(read_step(13'd10), BLANK_CELL, 7'd0, 6'd1, 1'b0));
        script.push_back(read_step(13'd0));
        // One row: a newline only blanks it.
        script.push_back(cfg_step(CFG_ROWS, 8'd1));
        script.push_back(with_reply(put_step(CH_LF, 4'h0, 4'h0), 16'h0000, 7'd0, 6'd0, 1'b1));
        // Zero sizes act as one cell.
        script.push_back(cfg_step(CFG_COLUMNS, 8'd0));
        script.push_back(cfg_step(CFG_ROWS, 8'd0));
        script.push_back(with_reply(put_step(8'h7A, 4'hC, 4'h3), 16'h0000, 7'd0, 6'd0, 1'b1));
        script.push_back(with_reply(read_step(13'd0), BLANK_CELL, 7'd0, 6'd0, 1'b0));
        // Oversized values clamp to the full 128x64 screen.
        script.push_back(cfg_step(CFG_COLUMNS, 8'hFF));
        script.push_back(cfg_step(CFG_ROWS, 8'hFF));
        script.push_back(with_reply(put_step(CH_LF, 4'h0, 4'h0), 16'h0000, 7'd0, 6'd1, 1'b0));
        script.push_back(with_reply(read_step(13'd8191), 16'h0000, 7'd0, 6'd1, 1'b0));

        phases.push_back(t_phase'{8'd16, 8'd6, 16'd300, 8'd8});
        phases.push_back(t_phase'{8'd8, 8'd3, 16'd150, 8'd10});
        phases.push_back(t_phase'{8'd1, 8'd1, 16'd40, 8'd5});
        phases.push_back(t_phase'{8'd255, 8'd255, 16'd120, 8'd45});
        phases.push_back(t_phase'{8'd128, 8'd2, 16'd100, 8'd10});
        phases.push_back(t_phase'{8'd3, 8'd64, 16'd100, 8'd10});
        phases.push_back(t_phase'{8'd0, 8'd0, 16'd30, 8'd5});
        phases.push_back(t_phase'{8'd80, 8'd25, 16'd100, 8'd20});
        phases.push_back(t_phase'{8'd5, 8'd200, 16'd60, 8'd10});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[s]) begin
            if (script[s].is_cfg) begin
                wait_idle();
                cfg_write(script[s].idx, script[s].data);
            end else begin
                offer(script[s].item, script[s].typed, script[s].want);
            end
        end

        foreach (phases[p]) begin
            wait_idle();
            cfg_write(CFG_COLUMNS, phases[p].cols);
            wait_idle();
            cfg_write(CFG_ROWS, phases[p].rows);
            send_phase(32'(phases[p].items), 32'(phases[p].lf_pct));
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
